// ----- sv/gslf_pkg.sv -----
// Shared types and constants for the shadowed grid light unit.
// Used by gslf_falloff and grid_shadowed_light_falloff_unit; depends on nothing.
package gslf_pkg;

    localparam int MAP_DIM_DEF    = 256;
    localparam int MAX_RADIUS_DEF = 31;

    localparam logic [2:0] CFG_ORIGIN_X  = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_Y  = 3'd1;
    localparam logic [2:0] CFG_RADIUS    = 3'd2;
    localparam logic [2:0] CFG_MAP_W     = 3'd3;
    localparam logic [2:0] CFG_MAP_H     = 3'd4;
    localparam logic [2:0] CFG_COLOR     = 3'd5;
    localparam logic [2:0] CFG_EXPONENT  = 3'd6;

    localparam logic       KIND_WRITE    = 1'b0;
    localparam logic [15:0] EXP_ONE      = 16'd4096;
    localparam logic [16:0] ONE_Q16      = 17'h10000;
    localparam logic [15:0] EXP_C1       = 16'd43024;
    localparam logic [15:0] EXP_C2       = 16'd22512;

    typedef struct packed {
        logic       kind;
        logic [7:0] tile_x;
        logic [7:0] tile_y;
        logic       solid_all_layers;
        logic       blocks_light;
    } t_in_item;

    typedef struct packed {
        logic        lit;
        logic [15:0] red_gain;
        logic [15:0] green_gain;
        logic [15:0] blue_gain;
        logic [15:0] alpha_gain;
    } t_out_item;

    typedef struct packed {
        logic        start;
        logic [10:0] d2;
        logic [4:0]  radius;
        logic [15:0] expo;
    } t_fo_req;

    typedef struct packed {
        logic        done;
        logic [16:0] fo;
    } t_fo_rsp;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_CHK, ST_WALK, ST_FALL, ST_GAIN, ST_DONE
    } t_state;

    typedef enum logic [3:0] {
        FO_IDLE, FO_DIV, FO_LOGD, FO_LOGR, FO_MULT, FO_CMP,
        FO_EXPA, FO_EXPB, FO_EXPC, FO_DONE
    } t_fo_state;

endpackage

// ----- sv/grid_shadowed_light_falloff_unit.sv -----
// Flow: a tile write, or a query rejected at acceptance, goes straight to the done state,
// and a query on a solid tile passes through the check state first. An open query passes
// through the check, walk, falloff and gain states.
// Throughput: one transaction at a time, set by the one-read-per-cycle tile memory
// walk and the bit-serial divider and log2 loops. After reset the tile memory is
// swept to zero, one entry per cycle, over all MAP_DIM*MAP_DIM entries before input is taken.
module grid_shadowed_light_falloff_unit import gslf_pkg::*; #(
    parameter int MAP_DIM    = MAP_DIM_DEF,
    parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int DEPTH = MAP_DIM * MAP_DIM;
    localparam int DAW   = $clog2(DEPTH);

    logic [7:0]  r_origin_x, r_origin_y;
    logic [4:0]  r_radius;
    logic [8:0]  r_map_w, r_map_h;
    logic [31:0] r_color;
    logic [15:0] r_expo;

    t_state      r_state, n_state;
    logic [DAW-1:0] r_clr, n_clr;
    logic [7:0]  r_u, n_u, r_v, n_v;
    logic [4:0]  r_ax, n_ax, r_ay, n_ay, r_cnt, n_cnt;
    logic        r_dxneg, n_dxneg, r_dxnz, n_dxnz, r_dyneg, n_dyneg, r_dynz, n_dynz;
    logic [7:0]  r_err, n_err;
    logic        r_pend, n_pend, r_pend_in, n_pend_in;
    logic [16:0] r_fo, n_fo;
    t_out_item   r_res, n_res;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out_item, n_out_item;

    logic [1:0]  mem [DEPTH];
    logic [1:0]  r_rd_data;
    logic        n_we;
    logic [DAW-1:0] n_waddr, n_raddr;
    logic [1:0]  n_wdata;

    logic [10:0] w_eff, h_eff;
    logic [4:0]  r_eff;
    logic signed [8:0] dx, dy;
    logic [8:0]  adx, ady;
    logic        xmaj, minor, step_u, step_v;
    logic [7:0]  err_a, lim, err_n, u_n, v_n;
    logic        inb;
    t_fo_req     fo_req;
    t_fo_rsp     fo_rsp;
    logic        in_acc;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_radius   <= 5'd1;
            r_map_w    <= 9'd256;
            r_map_h    <= 9'd256;
            r_color    <= '0;
            r_expo     <= EXP_ONE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_ORIGIN_X: r_origin_x <= i_cfg_data[7:0];
                CFG_ORIGIN_Y: r_origin_y <= i_cfg_data[7:0];
                CFG_RADIUS:   r_radius   <= i_cfg_data[4:0];
                CFG_MAP_W:    r_map_w    <= i_cfg_data[8:0];
                CFG_MAP_H:    r_map_h    <= i_cfg_data[8:0];
                CFG_COLOR:    r_color    <= i_cfg_data;
                CFG_EXPONENT: r_expo     <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_we) begin
            mem[n_waddr] <= n_wdata;
        end
        r_rd_data <= mem[n_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
        end
        r_u <= n_u;         r_v <= n_v;         r_ax <= n_ax;       r_ay <= n_ay;
        r_cnt <= n_cnt;     r_err <= n_err;     r_pend_in <= n_pend_in;
        r_dxneg <= n_dxneg; r_dxnz <= n_dxnz;   r_dyneg <= n_dyneg; r_dynz <= n_dynz;
        r_fo <= n_fo;       r_res <= n_res;     r_out_item <= n_out_item;
    end

    gslf_falloff u_falloff (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (fo_req),
        .o_rsp   (fo_rsp)
    );

    always_comb begin
        w_eff = (11'(r_map_w) < 11'(MAP_DIM)) ? 11'(r_map_w) : 11'(MAP_DIM);
        h_eff = (11'(r_map_h) < 11'(MAP_DIM)) ? 11'(r_map_h) : 11'(MAP_DIM);
        if (r_radius == '0) begin
            r_eff = 5'd1;
        end else if (8'(r_radius) > 8'(MAX_RADIUS)) begin
            r_eff = 5'(MAX_RADIUS);
        end else begin
            r_eff = r_radius;
        end
        dx  = $signed({1'b0, i_in_item.tile_x}) - $signed({1'b0, r_origin_x});
        dy  = $signed({1'b0, i_in_item.tile_y}) - $signed({1'b0, r_origin_y});
        adx = dx[8] ? 9'(-dx) : 9'(dx);
        ady = dy[8] ? 9'(-dy) : 9'(dy);

        xmaj   = r_ax >= r_ay;
        err_a  = r_err + (xmaj ? {2'b0, r_ay, 1'b0} : {2'b0, r_ax, 1'b0});
        lim    = xmaj ? {2'b0, r_ax, 1'b0} : {2'b0, r_ay, 1'b0};
        minor  = err_a >= lim;
        err_n  = minor ? err_a - lim : err_a;
        step_u = (xmaj || minor) && r_dxnz;
        step_v = (!xmaj || minor) && r_dynz;
        u_n    = step_u ? (r_dxneg ? r_u + 8'd1 : r_u - 8'd1) : r_u;
        v_n    = step_v ? (r_dyneg ? r_v + 8'd1 : r_v - 8'd1) : r_v;
        inb    = (11'(u_n) < w_eff) && (11'(v_n) < h_eff);
    end

    always_comb begin
        n_state = r_state; n_clr = r_clr; n_u = r_u; n_v = r_v; n_ax = r_ax;
        n_ay = r_ay; n_cnt = r_cnt; n_err = r_err; n_pend = r_pend;
        n_pend_in = r_pend_in; n_dxneg = r_dxneg; n_dxnz = r_dxnz;
        n_dyneg = r_dyneg; n_dynz = r_dynz; n_fo = r_fo; n_res = r_res;
        n_out_item = r_out_item;
        n_out_valid = r_out_valid && !i_out_ready;
        n_we = 1'b0;
        n_waddr = DAW'(32'(i_in_item.tile_y) * 32'(MAP_DIM) + 32'(i_in_item.tile_x));
        n_wdata = {i_in_item.blocks_light, i_in_item.solid_all_layers};
        n_raddr = n_waddr;
        fo_req = '{start: 1'b0,
                   d2: 11'({6'd0, r_ax} * {6'd0, r_ax}) + 11'({6'd0, r_ay} * {6'd0, r_ay}),
                   radius: r_eff, expo: r_expo};
        unique case (r_state)
            ST_CLEAR: begin
                n_we = 1'b1;
                n_waddr = r_clr;
                n_wdata = '0;
                n_clr = r_clr + DAW'(1);
                if (r_clr == DAW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    n_res = '0;
                    n_state = ST_DONE;
                    n_u = i_in_item.tile_x;
                    n_v = i_in_item.tile_y;
                    n_ax = adx[4:0];
                    n_ay = ady[4:0];
                    n_dxneg = dx[8];
                    n_dxnz = dx != '0;
                    n_dyneg = dy[8];
                    n_dynz = dy != '0;
                    if (i_in_item.kind == KIND_WRITE) begin
                        n_we = (11'(i_in_item.tile_x) < 11'(MAP_DIM)) &&
                               (11'(i_in_item.tile_y) < 11'(MAP_DIM));
                    end else if ((11'(i_in_item.tile_x) < w_eff) &&
                                 (11'(i_in_item.tile_y) < h_eff) &&
                                 (adx <= 9'(r_eff)) && (ady <= 9'(r_eff))) begin
                        n_state = ST_CHK;
                    end
                end
            end
            ST_CHK: begin
                n_pend = 1'b0;
                n_cnt = (r_ax >= r_ay) ? r_ax : r_ay;
                n_err = {3'b0, n_cnt};
                n_state = r_rd_data[0] ? ST_DONE : ST_WALK;
            end
            ST_WALK: begin
                if (r_pend && r_pend_in && r_rd_data[1]) begin
                    n_pend = 1'b0;
                    n_state = ST_DONE;
                end else if (r_cnt == '0) begin
                    n_pend = 1'b0;
                    fo_req.start = 1'b1;
                    n_state = ST_FALL;
                end else begin
                    n_u = u_n;
                    n_v = v_n;
                    n_err = err_n;
                    n_raddr = DAW'(32'(v_n) * 32'(MAP_DIM) + 32'(u_n));
                    n_pend = 1'b1;
                    n_pend_in = inb;
                    n_cnt = r_cnt - 5'd1;
                end
            end
            ST_FALL: begin
                if (fo_rsp.done) begin
                    n_fo = fo_rsp.fo;
                    n_state = ST_GAIN;
                end
            end
            ST_GAIN: begin
                n_res.lit = 1'b1;
                n_res.red_gain   = 16'((25'(r_color[7:0])   * 25'(ONE_Q16 - r_fo)) >> 8);
                n_res.green_gain = 16'((25'(r_color[15:8])  * 25'(ONE_Q16 - r_fo)) >> 8);
                n_res.blue_gain  = 16'((25'(r_color[23:16]) * 25'(ONE_Q16 - r_fo)) >> 8);
                n_res.alpha_gain = 16'((25'(r_color[31:24]) * 25'(ONE_Q16 - r_fo)) >> 8);
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_item = r_res;
                    n_out_valid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !o_in_ready)
        else $error("Input accepted during the tile memory clear.");
    a_unlit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.lit) |->
        (o_out_item.red_gain == '0 && o_out_item.green_gain == '0 &&
         o_out_item.blue_gain == '0 && o_out_item.alpha_gain == '0))
        else $error("Unlit result carries nonzero gain.");
    a_fo_done_in_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fo_rsp.done |-> (r_state == ST_FALL))
        else $error("Falloff finished outside the wait state.");
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != ST_IDLE))
        else $error("Transaction accepted but the controller stayed idle.");
`endif

endmodule

// ----- sv/gslf_falloff.sv -----
// Sequential falloff unit: restoring divider, squaring log2 and exp2 polynomial.
// Depends on gslf_pkg for request and response types and constants.
module gslf_falloff import gslf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_fo_req i_req,
    output t_fo_rsp o_rsp
);

    t_fo_state   r_state, n_state;
    logic [4:0]  r_cnt, n_cnt;
    logic [26:0] r_dq, n_dq;
    logic [4:0]  r_rem, n_rem;
    logic [30:0] r_m, n_m;
    logic [3:0]  r_k, n_k;
    logic [15:0] r_frac, n_frac;
    logic [19:0] r_l, n_l;
    logic [18:0] r_lr, n_lr;
    logic [23:0] r_t, n_t;
    logic [2:0]  r_i, n_i;
    logic [15:0] r_g, n_g;
    logic [31:0] r_gg, n_gg;
    logic [31:0] r_c1g, n_c1g;
    logic [30:0] r_c2, n_c2;
    logic [16:0] r_fo, n_fo;
    logic [4:0]  r_r, n_r;
    logic [15:0] r_e, n_e;

    logic [5:0]  rem_sh;
    logic        qbit;
    logic [26:0] q_n;
    logic [61:0] sq;
    logic [31:0] sq_s;
    logic        lbit;
    logic [30:0] m_step;
    logic [15:0] frac_n;
    logic [3:0]  ik;
    logic [30:0] im;
    logic [10:0] init_n;
    logic [18:0] nq;
    logic [32:0] psum;
    logic [17:0] pval;

    function automatic logic [3:0] msb_idx(input logic [10:0] n);
        logic [3:0] idx;
        idx = 4'd0;
        for (int b = 0; b < 11; b++) begin
            if (n[b]) idx = 4'(b);
        end
        return idx;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FO_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_cnt <= n_cnt;   r_dq <= n_dq;     r_rem <= n_rem;   r_m <= n_m;
        r_k <= n_k;       r_frac <= n_frac; r_l <= n_l;       r_lr <= n_lr;
        r_t <= n_t;       r_i <= n_i;       r_g <= n_g;       r_gg <= n_gg;
        r_c1g <= n_c1g;   r_c2 <= n_c2;     r_fo <= n_fo;     r_r <= n_r;
        r_e <= n_e;
    end

    always_comb begin
        rem_sh = {r_rem, r_dq[26]};
        qbit   = rem_sh >= {1'b0, r_r};
        q_n    = {r_dq[25:0], qbit};
        sq     = 62'(r_m) * 62'(r_m);
        sq_s   = sq[61:30];
        lbit   = sq_s[31];
        m_step = lbit ? sq_s[31:1] : sq_s[30:0];
        frac_n = {r_frac[14:0], lbit};
        init_n = (r_state == FO_LOGD) ? {6'd0, r_r} : i_req.d2;
        ik     = msb_idx(init_n);
        im     = 31'(({30'd0, init_n} << 30) >> ik);
        nq     = r_lr - r_t[18:0];
        psum   = 33'(r_c1g) + 33'(r_c2);
        pval   = 18'(ONE_Q16) + 18'(psum >> 16);
    end

    always_comb begin
        n_state = r_state; n_cnt = r_cnt; n_dq = r_dq; n_rem = r_rem; n_m = r_m;
        n_k = r_k; n_frac = r_frac; n_l = r_l; n_lr = r_lr; n_t = r_t; n_i = r_i;
        n_g = r_g; n_gg = r_gg; n_c1g = r_c1g; n_c2 = r_c2; n_fo = r_fo;
        n_r = r_r; n_e = r_e;
        o_rsp = '{done: 1'b0, fo: r_fo};
        unique case (r_state)
            FO_IDLE: begin
                if (i_req.start) begin
                    n_r = i_req.radius;
                    n_e = i_req.expo;
                    n_rem = '0;
                    n_cnt = 5'd26;
                    n_frac = '0;
                    n_k = ik;
                    n_m = im;
                    if (i_req.expo == '0) begin
                        n_dq = 27'(ONE_Q16);
                        n_state = FO_DIV;
                    end else if (i_req.d2 == '0) begin
                        n_fo = '0;
                        n_state = FO_DONE;
                    end else if (i_req.expo == EXP_ONE) begin
                        n_dq = {i_req.d2, 16'd0};
                        n_state = FO_DIV;
                    end else begin
                        n_cnt = 5'd15;
                        n_state = FO_LOGD;
                    end
                end
            end
            FO_DIV: begin
                n_rem = qbit ? 5'(rem_sh - {1'b0, r_r}) : rem_sh[4:0];
                n_dq = q_n;
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == '0) begin
                    n_fo = (q_n > 27'(ONE_Q16)) ? ONE_Q16 : q_n[16:0];
                    n_state = FO_DONE;
                end
            end
            FO_LOGD: begin
                n_m = m_step;
                n_frac = frac_n;
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == '0) begin
                    n_l = {r_k, frac_n};
                    n_k = ik;
                    n_m = im;
                    n_frac = '0;
                    n_cnt = 5'd15;
                    n_state = FO_LOGR;
                end
            end
            FO_LOGR: begin
                n_m = m_step;
                n_frac = frac_n;
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == '0) begin
                    n_lr = {r_k[2:0], frac_n};
                    n_state = FO_MULT;
                end
            end
            FO_MULT: begin
                n_t = 24'((36'(r_l) * 36'(r_e)) >> 12);
                n_state = FO_CMP;
            end
            FO_CMP: begin
                n_i = nq[18:16];
                n_g = 16'(ONE_Q16 - {1'b0, nq[15:0]});
                if (r_t >= 24'(r_lr)) begin
                    n_fo = ONE_Q16;
                    n_state = FO_DONE;
                end else if (nq[15:0] == '0) begin
                    n_fo = ONE_Q16 >> nq[18:16];
                    n_state = FO_DONE;
                end else begin
                    n_state = FO_EXPA;
                end
            end
            FO_EXPA: begin
                n_gg = 32'(r_g) * 32'(r_g);
                n_c1g = 32'(EXP_C1) * 32'(r_g);
                n_state = FO_EXPB;
            end
            FO_EXPB: begin
                n_c2 = 31'((48'(EXP_C2) * 48'(r_gg)) >> 16);
                n_state = FO_EXPC;
            end
            FO_EXPC: begin
                n_fo = 17'(pval >> (4'(r_i) + 4'd1));
                n_state = FO_DONE;
            end
            FO_DONE: begin
                o_rsp.done = 1'b1;
                n_state = FO_IDLE;
            end
            default: n_state = FO_IDLE;
        endcase
    end

endmodule

// ----- tb/tb_grid_shadowed_light_falloff_unit.sv -----
// Self-checking testbench for grid_shadowed_light_falloff_unit: tile writes and light queries
// are predicted by a local model of the map, walk and falloff, and checked by a scoreboard.
// Depends on gslf_pkg and the unit's RTL.
`timescale 1ns / 100ps

class light_scoreboard;
    bit [1:0]    tiles [0:65535];
    bit [7:0]    org_x, org_y;
    bit [4:0]    radius;
    bit [8:0]    map_w, map_h;
    bit [31:0]   color;
    bit [15:0]   expo;
    gslf_pkg::t_out_item pending [$];
    int          errors;

    function new();
        foreach (tiles[i]) tiles[i] = 2'b00;
        org_x = 0; org_y = 0; radius = 1; map_w = 256; map_h = 256;
        color = 0; expo = 16'd4096; errors = 0;
    endfunction

    function void set_reg(bit [2:0] idx, bit [31:0] val);
        case (idx)
            gslf_pkg::CFG_ORIGIN_X: org_x = val[7:0];
            gslf_pkg::CFG_ORIGIN_Y: org_y = val[7:0];
            gslf_pkg::CFG_RADIUS:   radius = val[4:0];
            gslf_pkg::CFG_MAP_W:    map_w = val[8:0];
            gslf_pkg::CFG_MAP_H:    map_h = val[8:0];
            gslf_pkg::CFG_COLOR:    color = val;
            gslf_pkg::CFG_EXPONENT: expo = val[15:0];
            default: ;
        endcase
    endfunction

    function longint log2_fix(longint n);
        longint k, fr, m;
        k = 0; fr = 0;
        if (n == 0) return 0;
        while (k < 31 && (n >> (k + 1)) != 0) k++;
        m = (n << 30) >> k;
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 30;
            fr = fr << 1;
            if (m >= (longint'(1) << 31)) begin
                fr = fr | 1; m = m >> 1;
            end
        end
        return (k << 16) | fr;
    endfunction

    function longint pow2_neg(longint n);
        longint i, f, g, p;
        i = n >> 16; f = n & 16'hFFFF;
        if (f == 0) return (i > 16) ? 0 : (longint'(65536) >> i);
        if (i + 1 >= 32) return 0;
        g = 65536 - f;
        p = 65536 + ((43024 * g + ((22512 * g * g) >> 16)) >> 16);
        return p >> (i + 1);
    endfunction

    function longint falloff(longint d2, longint r, longint e);
        longint t, lr, q;
        if (e == 0) return 65536 / r;
        if (d2 == 0) return 0;
        if (e == 4096) begin
            q = (d2 << 16) / r;
            return (q > 65536) ? 65536 : q;
        end
        t = (log2_fix(d2) * e) >> 12;
        lr = log2_fix(r);
        if (t >= lr) return 65536;
        return pow2_neg(lr - t);
    endfunction

    function bit shadowed(int u, int v, int dx, int dy, int w, int h);
        int ax, ay, sx, sy, err, steps;
        ax = dx < 0 ? -dx : dx; ay = dy < 0 ? -dy : dy;
        sx = dx > 0 ? 1 : (dx < 0 ? -1 : 0); sy = dy > 0 ? 1 : (dy < 0 ? -1 : 0);
        steps = ax >= ay ? ax : ay;
        err = steps;
        for (int i = 0; i < steps; i++) begin
            if (ax >= ay) begin
                u -= sx; err += 2 * ay;
                if (err >= 2 * ax) begin
                    err -= 2 * ax; v -= sy;
                end
            end else begin
                v -= sy; err += 2 * ax;
                if (err >= 2 * ay) begin
                    err -= 2 * ay; u -= sx;
                end
            end
            if (u >= 0 && u < w && v >= 0 && v < h && tiles[v * 256 + u][1]) return 1;
        end
        return 0;
    endfunction

    function void note_input(gslf_pkg::t_in_item it);
        gslf_pkg::t_out_item res;
        int w, h, r, dx, dy, adx, ady;
        longint fo, lvl;
        res = '0;
        if (it.kind == gslf_pkg::KIND_WRITE) begin
            tiles[{it.tile_y, it.tile_x}] = {it.blocks_light, it.solid_all_layers};
        end else begin
            w = map_w < 256 ? map_w : 256;
            h = map_h < 256 ? map_h : 256;
            r = radius == 0 ? 1 : radius;
            dx = int'(it.tile_x) - int'(org_x);
            dy = int'(it.tile_y) - int'(org_y);
            adx = dx < 0 ? -dx : dx; ady = dy < 0 ? -dy : dy;
            if (it.tile_x < w && it.tile_y < h && adx <= r && ady <= r
                    && !tiles[{it.tile_y, it.tile_x}][0]
                    && !shadowed(it.tile_x, it.tile_y, dx, dy, w, h)) begin
                fo = falloff(adx * adx + ady * ady, r, expo);
                res.lit = 1'b1;
                lvl = color[7:0];   res.red_gain   = 16'((lvl * (65536 - fo)) >> 8);
                lvl = color[15:8];  res.green_gain = 16'((lvl * (65536 - fo)) >> 8);
                lvl = color[23:16]; res.blue_gain  = 16'((lvl * (65536 - fo)) >> 8);
                lvl = color[31:24]; res.alpha_gain = 16'((lvl * (65536 - fo)) >> 8);
            end
        end
        pending.push_back(res);
    endfunction

    task report(string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        errors++;
    endtask

    task check_result(gslf_pkg::t_out_item got);
        gslf_pkg::t_out_item exp_item;
        if (pending.size() == 0) begin
            report("result with no transaction outstanding");
        end else begin
            exp_item = pending.pop_front();
            if (got.lit != exp_item.lit)
                report($sformatf("lit %0d, expected %0d", got.lit, exp_item.lit));
            if (got.red_gain != exp_item.red_gain)
                report($sformatf("red %0d, expected %0d", got.red_gain, exp_item.red_gain));
            if (got.green_gain != exp_item.green_gain)
                report($sformatf("green %0d, expected %0d", got.green_gain,
                                 exp_item.green_gain));
            if (got.blue_gain != exp_item.blue_gain)
                report($sformatf("blue %0d, expected %0d", got.blue_gain, exp_item.blue_gain));
            if (got.alpha_gain != exp_item.alpha_gain)
                report($sformatf("alpha %0d, expected %0d", got.alpha_gain,
                                 exp_item.alpha_gain));
        end
    endtask
endclass

module tb_grid_shadowed_light_falloff_unit;
    import gslf_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_item    i_in_item;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_item   o_out_item;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    light_scoreboard sb;
    int  idle_cycles;
    bit  timed_out;

    grid_shadowed_light_falloff_unit uut (.*);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out_item);
    end

    // Receiver: random stall between transactions.
    initial begin
        int gap;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_out_ready && o_out_valid) begin
                gap = $urandom_range(0, 7);
                if (gap != 0) begin
                    i_out_ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                i_out_ready <= 1'b1;
            end else if (i_rst_n) begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Watchdog over cycles with no accepted transaction; the limit covers the clear sweep.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 400000 && !timed_out) begin
            timed_out = 1;
            $display("Some tests failed");
            $finish;
        end
    end

    // Valid stays high after a write; set_light drops it after the last register.
    task write_reg(bit [2:0] idx, bit [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, val);
    endtask

    // Valid stays high after acceptance until the next item or wait_drained takes over.
    task send_item(t_in_item it);
        int gap;
        gap = $urandom_range(0, 7);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(it);
    endtask

    task wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    function t_in_item make_item(bit kind, int x, int y, bit solid, bit blk);
        t_in_item it;
        it.kind = kind; it.tile_x = x[7:0]; it.tile_y = y[7:0];
        it.solid_all_layers = solid; it.blocks_light = blk;
        return it;
    endfunction

    task set_light(int ox, int oy, int r, int w, int h, bit [31:0] col, int e);
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Y, oy);
        write_reg(CFG_RADIUS, r);
        write_reg(CFG_MAP_W, w);
        write_reg(CFG_MAP_H, h);
        write_reg(CFG_COLOR, col);
        write_reg(CFG_EXPONENT, e);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly queries near the origin, with writes that build walls around it.
    task random_phase(int count);
        int ox, oy, r, dx, dy;
        bit kind;
        ox = sb.org_x; oy = sb.org_y; r = (sb.radius == 0) ? 1 : sb.radius;
        for (int n = 0; n < count; n++) begin
            kind = ($urandom_range(0, 99) < 60);
            dx = $urandom_range(0, 2 * r + 2) - r - 1;
            dy = $urandom_range(0, 2 * r + 2) - r - 1;
            if ($urandom_range(0, 9) == 0)
                send_item(make_item(kind, $urandom_range(0, 255), $urandom_range(0, 255),
                                    $urandom_range(0, 1), $urandom_range(0, 1)));
            else
                send_item(make_item(kind, ox + dx, oy + dy,
                                    $urandom_range(0, 5) == 0, $urandom_range(0, 3) == 0));
        end
    endtask

    initial begin
        sb = new();
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        idle_cycles = 0;
        timed_out = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset registers, then origin tile, corners, walls and edge cases.
        send_item(make_item(1'b1, 0, 0, 0, 0));
        wait_drained();
        set_light(10, 10, 5, 256, 256, 32'hFF80_40FF, 4096);
        send_item(make_item(1'b1, 10, 10, 0, 0));
        send_item(make_item(1'b1, 15, 15, 0, 0));
        send_item(make_item(1'b1, 5, 12, 0, 0));
        send_item(make_item(1'b1, 16, 10, 0, 0));
        send_item(make_item(1'b0, 12, 10, 0, 1));
        send_item(make_item(1'b1, 14, 10, 0, 0));
        send_item(make_item(1'b1, 12, 10, 0, 0));
        send_item(make_item(1'b0, 13, 13, 1, 0));
        send_item(make_item(1'b1, 13, 13, 0, 0));
        send_item(make_item(1'b0, 10, 10, 1, 1));
        send_item(make_item(1'b1, 8, 8, 0, 0));
        send_item(make_item(1'b0, 10, 10, 0, 0));
        send_item(make_item(1'b0, 255, 255, 1, 1));
        send_item(make_item(1'b1, 7, 9, 0, 0));
        wait_drained();
        set_light(255, 255, 31, 256, 256, 32'hFFFF_FFFF, 0);
        send_item(make_item(1'b1, 255, 255, 0, 0));
        send_item(make_item(1'b1, 224, 224, 0, 0));
        send_item(make_item(1'b1, 254, 240, 0, 0));
        wait_drained();
        set_light(0, 0, 0, 0, 300, 32'h1234_5678, 65535);
        send_item(make_item(1'b1, 0, 0, 0, 0));
        send_item(make_item(1'b1, 1, 0, 0, 0));
        wait_drained();

        // Random phases through several light settings.
        for (int p = 0; p < 18; p++) begin
            case (p % 6)
                0: set_light($urandom_range(0, 255), $urandom_range(0, 255),
                             $urandom_range(1, 8), 256, 256, $urandom, 4096);
                1: set_light($urandom_range(0, 255), $urandom_range(0, 255),
                             31, 256, 256, $urandom, 0);
                2: set_light($urandom_range(0, 40), $urandom_range(0, 40),
                             $urandom_range(1, 31), $urandom_range(1, 40),
                             $urandom_range(1, 40), $urandom, $urandom_range(0, 65535));
                3: set_light($urandom_range(200, 255), $urandom_range(200, 255),
                             $urandom_range(0, 31), $urandom_range(200, 511),
                             $urandom_range(200, 511), $urandom, $urandom_range(1, 16384));
                4: set_light($urandom_range(0, 255), $urandom_range(0, 255),
                             $urandom_range(1, 12), 256, 256, 32'hFFFF_FFFF, 8192);
                default: set_light($urandom_range(0, 255), $urandom_range(0, 255),
                                   $urandom_range(1, 31), 256, 256, $urandom,
                                   $urandom_range(0, 65535));
            endcase
            random_phase(100);
            wait_drained();
        end

        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

// ----- sim.f -----
sv/gslf_pkg.sv
sv/gslf_falloff.sv
sv/grid_shadowed_light_falloff_unit.sv
tb/tb_grid_shadowed_light_falloff_unit.sv
